[hdl/thpc_pkg.sv]
// Package: shared types and constants for the TCP header parse/check block
package thpc_pkg;

  localparam int LenW = 16;
  localparam logic [LenW-1:0] LenMax = {LenW{1'b1}};
  localparam logic [LenW-1:0] BaseHdr = LenW'(20);
  localparam logic [15:0] WatchPortRst = 16'd80;

  // status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_SHORT   = 3'd1;
  localparam logic [2:0] ST_HDR_LOW = 3'd2;
  localparam logic [2:0] ST_HDR_END = 3'd3;
  localparam logic [2:0] ST_URGENT  = 3'd4;

  // option walk phases
  localparam logic [1:0] PH_KIND = 2'd0;
  localparam logic [1:0] PH_LEN  = 2'd1;
  localparam logic [1:0] PH_SKIP = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  // option kinds
  localparam logic [7:0] OPT_END  = 8'h00;
  localparam logic [7:0] OPT_NOP  = 8'h01;
  localparam logic [7:0] OPT_MSS  = 8'h02;
  localparam logic [7:0] OPT_WS   = 8'h03;
  localparam logic [7:0] OPT_SOK  = 8'h04;
  localparam logic [7:0] OPT_SACK = 8'h05;
  localparam logic [7:0] OPT_TS   = 8'h08;
  localparam logic [7:0] OPT_MP   = 8'h1e;

  // option error bits
  localparam logic [3:0] OE_OVERRUN = 4'h1;
  localparam logic [3:0] OE_SHORT   = 4'h2;
  localparam logic [3:0] OE_BADLEN  = 4'h4;
  localparam logic [3:0] OE_UNKNOWN = 4'h8;

  // segment classes
  localparam logic [2:0] CL_NONE  = 3'd0;
  localparam logic [2:0] CL_SYN   = 3'd1;
  localparam logic [2:0] CL_SYNACK= 3'd2;
  localparam logic [2:0] CL_FIN   = 3'd3;
  localparam logic [2:0] CL_ACK   = 3'd4;
  localparam logic [2:0] CL_RST   = 3'd5;
  localparam logic [2:0] CL_IGN   = 3'd6;
  localparam logic [2:0] CL_UNEXP = 3'd7;

  localparam int QDepth = 2;

  typedef struct packed {
    logic [7:0] seg_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] sport;
    logic [15:0] dport;
    logic [31:0] seq_no;
    logic [31:0] ack_no;
    logic [5:0]  header_len;
    logic [7:0]  tcp_flags;
    logic [2:0]  status;
    logic [3:0]  option_errors;
    logic [2:0]  segment_class;
    logic        has_payload;
    logic        payload_watched;
    logic [15:0] payload_len;
  } out_beat_t;

  // segment summary passed from front to back
  typedef struct packed {
    logic [15:0]     sport;
    logic [15:0]     dport;
    logic [31:0]     seq_no;
    logic [31:0]     ack_no;
    logic [5:0]      header_len;
    logic [7:0]      tcp_flags;
    logic [15:0]     urgent;
    logic [3:0]      opt_err;
    logic [LenW-1:0] seg_len;
  } seg_sum_t;

  function automatic logic [2:0] classify(input logic [7:0] flags);
    logic [2:0] c;
    case (flags[5:0])
      6'h02: c = CL_SYN;
      6'h12: c = CL_SYNACK;
      6'h01, 6'h11, 6'h19: c = CL_FIN;
      6'h10, 6'h18: c = CL_ACK;
      6'h04, 6'h14: c = CL_RST;
      6'h15, 6'h1C: c = CL_IGN;
      default: c = CL_UNEXP;
    endcase
    return c;
  endfunction

endpackage

[hdl/thpc_front.sv]
// Front end: byte counter, header capture and option walk; emits a summary per segment
module thpc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  thpc_pkg::in_beat_t  in_data,
  input  logic                in_fire,
  output logic                sum_valid,
  output thpc_pkg::seg_sum_t  sum_data
);

  logic [thpc_pkg::LenW-1:0] cnt_r, cnt_nxt;
  logic [1:0] ph_r, ph_nxt;
  logic [7:0] kind_r, kind_nxt;
  logic [7:0] skip_r, skip_nxt;
  logic [3:0] oe_r, oe_nxt;
  logic [3:0] oe_walk;
  logic [7:0] hdr_r [20];
  logic [5:0] hl;
  logic [thpc_pkg::LenW-1:0] hl_w, pos1, cnt_inc;
  logic [thpc_pkg::LenW+8:0] end_pos;
  logic [7:0] b;

  assign b    = in_data.seg_byte;
  assign hl   = hdr_r[12][7:2];
  assign hl_w = thpc_pkg::LenW'(hl);
  assign pos1 = cnt_r + 1'b1;
  assign end_pos = (thpc_pkg::LenW+9)'(cnt_r) + (thpc_pkg::LenW+9)'(b) - 1'b1;
  assign cnt_inc = (cnt_r == thpc_pkg::LenMax) ? cnt_r : pos1;

  // header capture
  always_ff @(posedge clk) begin
    if (in_fire && cnt_r < thpc_pkg::BaseHdr) begin
      hdr_r[cnt_r[4:0]] <= b;
    end
  end

  // option walk
  always_comb begin
    ph_nxt = ph_r;
    kind_nxt = kind_r;
    skip_nxt = skip_r;
    oe_nxt = oe_r;
    if (cnt_r >= thpc_pkg::BaseHdr && cnt_r < hl_w) begin
      case (ph_r)
        thpc_pkg::PH_KIND: begin
          if (b == thpc_pkg::OPT_END) begin
            ph_nxt = thpc_pkg::PH_DONE;
          end else if (b == thpc_pkg::OPT_NOP) begin
            ph_nxt = ph_r;
          end else if (pos1 >= hl_w) begin
            oe_nxt = oe_r | thpc_pkg::OE_OVERRUN;
            ph_nxt = thpc_pkg::PH_DONE;
          end else begin
            kind_nxt = b;
            ph_nxt = thpc_pkg::PH_LEN;
          end
        end
        thpc_pkg::PH_LEN: begin
          if (b < 8'd2) begin
            oe_nxt = oe_r | thpc_pkg::OE_SHORT;
            ph_nxt = thpc_pkg::PH_DONE;
          end else if (end_pos > (thpc_pkg::LenW+9)'(hl)) begin
            oe_nxt = oe_r | thpc_pkg::OE_OVERRUN;
            ph_nxt = thpc_pkg::PH_DONE;
          end else begin
            case (kind_r)
              thpc_pkg::OPT_MSS: if (b != 8'd4) oe_nxt = oe_r | thpc_pkg::OE_BADLEN;
              thpc_pkg::OPT_SOK: if (b != 8'd2) oe_nxt = oe_r | thpc_pkg::OE_BADLEN;
              thpc_pkg::OPT_SACK, thpc_pkg::OPT_TS,
              thpc_pkg::OPT_WS, thpc_pkg::OPT_MP: oe_nxt = oe_r;
              default: oe_nxt = oe_r | thpc_pkg::OE_UNKNOWN;
            endcase
            skip_nxt = b - 8'd2;
            ph_nxt = (b == 8'd2) ? thpc_pkg::PH_KIND : thpc_pkg::PH_SKIP;
          end
        end
        thpc_pkg::PH_SKIP: begin
          skip_nxt = skip_r - 8'd1;
          if (skip_r == 8'd1) ph_nxt = thpc_pkg::PH_KIND;
        end
        default: ph_nxt = ph_r;
      endcase
    end
    // error bits including this byte, before the end-of-segment clear
    oe_walk = oe_nxt;
    cnt_nxt = cnt_inc;
    if (in_data.last_byte) begin
      cnt_nxt = '0;
      ph_nxt = thpc_pkg::PH_KIND;
      kind_nxt = '0;
      skip_nxt = '0;
      oe_nxt = '0;
    end
  end

  // walk state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ph_r <= thpc_pkg::PH_KIND;
      kind_r <= '0;
      skip_r <= '0;
      oe_r <= '0;
    end else if (in_fire) begin
      cnt_r <= cnt_nxt;
      ph_r <= ph_nxt;
      kind_r <= kind_nxt;
      skip_r <= skip_nxt;
      oe_r <= oe_nxt;
    end
  end

  // summary of the segment, taken on the last beat
  assign sum_valid = in_fire && in_data.last_byte;
  always_comb begin
    sum_data.sport      = {hdr_r[0], hdr_r[1]};
    sum_data.dport      = {hdr_r[2], hdr_r[3]};
    sum_data.seq_no     = {hdr_r[4], hdr_r[5], hdr_r[6], hdr_r[7]};
    sum_data.ack_no     = {hdr_r[8], hdr_r[9], hdr_r[10], hdr_r[11]};
    sum_data.header_len = hl;
    sum_data.tcp_flags  = hdr_r[13];
    sum_data.urgent     = {hdr_r[18], hdr_r[19]};
    sum_data.opt_err    = oe_walk;
    sum_data.seg_len    = cnt_inc;
    // byte 19 lands on this beat for a 20-byte segment
    if (cnt_r == thpc_pkg::BaseHdr - 1'b1) sum_data.urgent[7:0] = b;
  end

endmodule

[hdl/thpc_queue.sv]
// Short summary queue between front and back ends
module thpc_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  thpc_pkg::seg_sum_t wr_data,
  output logic               full,
  output logic               rd_valid,
  input  logic               rd_en,
  output thpc_pkg::seg_sum_t rd_data
);

  thpc_pkg::seg_sum_t mem_r [thpc_pkg::QDepth];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full = (cnt_r == 2'(thpc_pkg::QDepth));
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data = mem_r[rp_r];

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr_en) - 2'(rd_en);
    end
  end

endmodule

[hdl/thpc_back.sv]
// Back end: status, class and payload checks, output register
module thpc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [15:0]         watch_port,
  input  logic                sum_valid,
  input  thpc_pkg::seg_sum_t  sum_data,
  output logic                sum_take,
  output logic                out_valid,
  input  logic                out_ready,
  output thpc_pkg::out_beat_t out_data
);

  logic out_valid_r;
  thpc_pkg::out_beat_t out_r, res;
  logic [thpc_pkg::LenW-1:0] hl_w;
  logic [2:0] st, cls;
  logic has_pl;

  assign hl_w = thpc_pkg::LenW'(sum_data.header_len);
  assign sum_take = sum_valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data = out_r;

  // checks
  always_comb begin
    if (hl_w < thpc_pkg::BaseHdr) st = thpc_pkg::ST_HDR_LOW;
    else if (hl_w > sum_data.seg_len) st = thpc_pkg::ST_HDR_END;
    else if (sum_data.tcp_flags[5] && sum_data.urgent != 16'd0) st = thpc_pkg::ST_URGENT;
    else st = thpc_pkg::ST_OK;
    cls = thpc_pkg::classify(sum_data.tcp_flags);
    has_pl = (cls == thpc_pkg::CL_ACK) && (sum_data.seg_len > hl_w);
    res = '0;
    if (sum_data.seg_len < thpc_pkg::BaseHdr) begin
      res.status = thpc_pkg::ST_SHORT;
    end else begin
      res.sport      = sum_data.sport;
      res.dport      = sum_data.dport;
      res.seq_no     = sum_data.seq_no;
      res.ack_no     = sum_data.ack_no;
      res.header_len = sum_data.header_len;
      res.tcp_flags  = sum_data.tcp_flags;
      res.status     = st;
      if (st == thpc_pkg::ST_OK) begin
        res.option_errors   = sum_data.opt_err;
        res.segment_class   = cls;
        res.has_payload     = has_pl;
        res.payload_watched = has_pl && (sum_data.dport == watch_port);
        res.payload_len     = 16'(sum_data.seg_len - hl_w);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (sum_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sum_take) out_r <= res;
  end

endmodule

[hdl/tcp_header_parse_check.sv]
// Top level: TCP header parser and checker
// Usage:
//  - in_*: one segment byte per beat, header first, in_data.last_byte marks the
//    final beat. A beat can be taken every cycle while the queue is not full.
//  - out_*: one result beat per segment, valid/ready.
//  - cfg_*: write of watch_port; write only while the block is idle.
// Result path: the summary queue is written on the edge that accepts the last
// byte; out_valid rises when the output register is loaded from the queue,
// which waits while the register is full. Throughput: one byte per cycle while
// the input is not stalled; the front end's option walk steps once per byte.
// The two-entry summary queue absorbs results while the receiver stalls; the
// input stalls on a last byte only when the queue is full.
// Reset (synchronous, rst_n low): counter and option walk cleared, queue and
// output emptied, watch_port returns to 80. Header bytes are not cleared.
module tcp_header_parse_check (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  thpc_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output thpc_pkg::out_beat_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_data
);

  logic [15:0] watch_port_r;
  logic in_fire, sum_valid, q_full, q_valid, q_take;
  thpc_pkg::seg_sum_t sum_data, q_data;

  assign in_ready = !q_full || !in_data.last_byte;
  assign in_fire = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) watch_port_r <= thpc_pkg::WatchPortRst;
    else if (cfg_valid) watch_port_r <= cfg_data;
  end

  thpc_front u_front (
    .clk(clk), .rst_n(rst_n), .in_data(in_data), .in_fire(in_fire),
    .sum_valid(sum_valid), .sum_data(sum_data)
  );

  thpc_queue u_queue (
    .clk(clk), .rst_n(rst_n), .wr_en(sum_valid), .wr_data(sum_data), .full(q_full),
    .rd_valid(q_valid), .rd_en(q_take), .rd_data(q_data)
  );

  thpc_back u_back (
    .clk(clk), .rst_n(rst_n), .watch_port(watch_port_r), .sum_valid(q_valid),
    .sum_data(q_data), .sum_take(q_take), .out_valid(out_valid),
    .out_ready(out_ready), .out_data(out_data)
  );

`ifndef SYNTHESIS
  // a summary is never pushed into a full queue
  assert property (@(posedge clk) disable iff (!rst_n) !(sum_valid && q_full))
    else $error("queue overflow");
  // stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed under stall");
  // fatal results carry no class
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != thpc_pkg::ST_OK |->
    out_data.segment_class == thpc_pkg::CL_NONE && !out_data.has_payload)
    else $error("class on fatal result");
`endif

endmodule
